// ===== rtl/core/gsn_pkg.sv =====
// Package for the GCR sector nibblizer: word types, stream constants, encode table.
package gsn_pkg;

    localparam int unsigned SECTOR_BYTES = 256;
    localparam int unsigned AUX_COUNT    = 86;

    localparam int unsigned AUX_AW = $clog2(AUX_COUNT);
    localparam int unsigned UP_AW  = $clog2(SECTOR_BYTES);

    localparam logic [8:0] LOAD_FULL   = 9'd256;
    localparam logic [8:0] FIRST_LIMIT = 9'd86;
    localparam logic [8:0] FIELD_START = 9'd35;
    localparam logic [8:0] AUX_START   = 9'd59;
    localparam logic [8:0] UP_START    = 9'd145;
    localparam logic [8:0] CHECK_POS   = 9'd401;
    localparam logic [8:0] LAST_POS    = 9'd420;

    localparam logic [7:0] VOLUME_RESET = 8'hFE;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [7:0] GCR_TABLE [0:63] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic [7:0] track;
        logic [7:0] sector;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    typedef struct packed {
        logic              aux_we;
        logic [AUX_AW-1:0] aux_waddr;
        logic [5:0]        aux_wdata;
        logic [AUX_AW-1:0] aux_raddr;
        logic              up_we;
        logic [UP_AW-1:0]  up_waddr;
        logic [5:0]        up_wdata;
        logic [UP_AW-1:0]  up_raddr;
    } mem_ctrl_t;

    function automatic logic [7:0] framing_nibble(
        input logic [8:0] p,
        input logic [7:0] vol,
        input logic [7:0] trk,
        input logic [7:0] sec
    );
        logic [8:0] idx;
        logic [7:0] v;
        logic [7:0] n;
        idx = p - FIELD_START;
        unique case (idx[2:1])
            2'd0:    v = vol;
            2'd1:    v = trk;
            2'd2:    v = sec;
            default: v = vol ^ trk ^ sec;
        endcase
        priority if (p < 9'd32)   n = 8'hFF;
        else if (p == 9'd32)      n = 8'hD5;
        else if (p == 9'd33)      n = 8'hAA;
        else if (p == 9'd34)      n = 8'h96;
        else if (p < 9'd43)       n = idx[0] ? ((v & 8'h55) | 8'hAA)
                                             : (((v >> 1) & 8'h55) | 8'hAA);
        else if (p == 9'd43)      n = 8'hDE;
        else if (p == 9'd44)      n = 8'hAA;
        else if (p == 9'd45)      n = 8'hEB;
        else if (p < 9'd56)       n = 8'hFF;
        else if (p == 9'd56)      n = 8'hD5;
        else if (p == 9'd57)      n = 8'hAA;
        else if (p == 9'd58)      n = 8'hAD;
        else if (p == 9'd402)     n = 8'hDE;
        else if (p == 9'd403)     n = 8'hAA;
        else if (p == 9'd404)     n = 8'hEB;
        else                      n = 8'hFF;
        return n;
    endfunction

endpackage

// ===== rtl/core/gsn_mem.sv =====
// Aux and upper-bits sector memories, one write and one registered read port each.
module gsn_mem
    import gsn_pkg::*;
(
    input  logic       clk,
    input  mem_ctrl_t  ctrl,
    output logic [5:0] aux_rdata,
    output logic [5:0] up_rdata
);

    logic [5:0] aux_mem [AUX_COUNT];
    logic [5:0] up_mem  [SECTOR_BYTES];

    always_ff @(posedge clk)
    begin
        if (ctrl.aux_we)
        begin
            aux_mem[ctrl.aux_waddr] <= ctrl.aux_wdata;
        end
        if (ctrl.up_we)
        begin
            up_mem[ctrl.up_waddr] <= ctrl.up_wdata;
        end
        aux_rdata <= aux_mem[ctrl.aux_raddr];
        up_rdata  <= up_mem[ctrl.up_raddr];
    end

endmodule

// ===== rtl/core/gsn_cfg.sv =====
// APB register file holding the volume number.
module gsn_cfg
    import gsn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  volume
);

    logic [7:0] volume_reg;
    logic [7:0] volume_next;

    always_comb
    begin
        volume_next = volume_reg;
        if (psel && penable && pwrite && !paddr[2])
        begin
            volume_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= VOLUME_RESET;
        end
        else
        begin
            volume_reg <= volume_next;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {24'd0, volume_reg};
    assign pready = 1'b1;
    assign volume = volume_reg;

endmodule

// ===== rtl/core/gsn_ctrl.sv =====
// Load and stream sequencer: read-modify-write of aux entries, nibble generation.
module gsn_ctrl
    import gsn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  item_t      item,
    input  logic [7:0] volume,
    input  logic [5:0] aux_rdata,
    input  logic [5:0] up_rdata,
    output logic       busy,
    output mem_ctrl_t  mem,
    output result_t    result,
    output logic       result_strobe
);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_PULL} state_t;

    state_t            state_reg, state_next;
    logic [8:0]        load_count_reg, load_count_next;
    logic [AUX_AW-1:0] aux_idx_reg, aux_idx_next;
    logic [8:0]        pos_reg, pos_next;
    logic [5:0]        rx_reg, rx_next;
    logic [7:0]        track_reg, track_next;
    logic [7:0]        sector_reg, sector_next;
    logic [AUX_AW-1:0] k_reg, k_next;
    logic [1:0]        pair_reg, pair_next;
    logic              first_reg, first_next;
    result_t           result_reg, result_next;
    logic              strobe_reg, strobe_next;

    logic       accept;
    logic       full;
    logic       do_load;
    logic       do_pull;
    logic [8:0] dpos;
    logic [8:0] upos;
    logic       in_aux;
    logic       in_up;
    logic [5:0] xnew;

    always_comb
    begin
        busy    = (state_reg != S_IDLE);
        accept  = start && !busy;
        full    = (load_count_reg >= LOAD_FULL);
        do_load = accept && (item.op == OP_LOAD) && !full;
        do_pull = accept && (item.op == OP_PULL) && full;
        dpos    = pos_reg - AUX_START;
        upos    = pos_reg - UP_START;
        in_aux  = (pos_reg >= AUX_START) && (pos_reg < UP_START);
        in_up   = (pos_reg >= UP_START) && (pos_reg < CHECK_POS);
        xnew    = rx_reg ^ (in_aux ? aux_rdata : up_rdata);

        mem.up_we     = do_load;
        mem.up_waddr  = load_count_reg[UP_AW-1:0];
        mem.up_wdata  = item.data_byte[7:2];
        mem.up_raddr  = upos[UP_AW-1:0];
        mem.aux_raddr = full ? dpos[AUX_AW-1:0] : aux_idx_reg;
        mem.aux_we    = (state_reg == S_LOAD);
        mem.aux_waddr = k_reg;
        mem.aux_wdata = first_reg ? {4'd0, pair_reg} : {aux_rdata[3:0], pair_reg};

        state_next      = state_reg;
        load_count_next = load_count_reg;
        aux_idx_next    = aux_idx_reg;
        pos_next        = pos_reg;
        rx_next         = rx_reg;
        track_next      = track_reg;
        sector_next     = sector_reg;
        k_next          = k_reg;
        pair_next       = pair_reg;
        first_next      = first_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (do_load)
                begin
                    if (load_count_reg == 9'd0)
                    begin
                        track_next  = item.track;
                        sector_next = item.sector;
                    end
                    k_next          = aux_idx_reg;
                    pair_next       = {item.data_byte[0], item.data_byte[1]};
                    first_next      = (load_count_reg < FIRST_LIMIT);
                    aux_idx_next    = (aux_idx_reg == AUX_AW'(AUX_COUNT - 1))
                                      ? '0 : aux_idx_reg + 1'b1;
                    load_count_next = load_count_reg + 1'b1;
                    state_next      = S_LOAD;
                end
                else if (do_pull)
                begin
                    state_next = S_PULL;
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_PULL:
            begin
                if (in_aux || in_up)
                begin
                    rx_next              = xnew;
                    result_next.out_byte = GCR_TABLE[xnew];
                end
                else if (pos_reg == CHECK_POS)
                begin
                    result_next.out_byte = GCR_TABLE[rx_reg];
                end
                else
                begin
                    result_next.out_byte = framing_nibble(pos_reg, volume,
                                                          track_reg, sector_reg);
                end
                result_next.last = (pos_reg == LAST_POS);
                strobe_next      = 1'b1;
                if (pos_reg == LAST_POS)
                begin
                    pos_next        = '0;
                    load_count_next = '0;
                    aux_idx_next    = '0;
                    rx_next         = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_count_reg <= '0;
            aux_idx_reg    <= '0;
            pos_reg        <= '0;
            rx_reg         <= '0;
            track_reg      <= '0;
            sector_reg     <= '0;
            k_reg          <= '0;
            pair_reg       <= '0;
            first_reg      <= 1'b0;
            result_reg     <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            aux_idx_reg    <= aux_idx_next;
            pos_reg        <= pos_next;
            rx_reg         <= rx_next;
            track_reg      <= track_next;
            sector_reg     <= sector_next;
            k_reg          <= k_next;
            pair_reg       <= pair_next;
            first_reg      <= first_next;
            result_reg     <= result_next;
            strobe_reg     <= strobe_next;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

// ===== rtl/core/gcr_sector_nibblizer.sv =====
// Top level of the GCR 6-and-2 sector nibblizer.
//
//  channel   direction  handshake                      word
//  item      in         start && !busy                 op, data_byte, track, sector
//  result    out        result_strobe, one cycle       out_byte, last
//  config    in         psel && penable && pwrite      volume_number at 0x0
//
//  An accepted load or pull holds busy for one cycle: the memory read of the
//  aux or upper-bits entry is registered before the write-back or the encode.
//  A pull's word is on result in the first cycle with busy low again; a new
//  item may be accepted in that same cycle, but none while busy is high.
//  Early pulls and extra loads are dropped at once without raising busy.
//  rst_n clears all control state asynchronously; memories are not cleared.
module gcr_sector_nibblizer
    import gsn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    output result_t     result,
    output logic        result_strobe
);

    logic [7:0] volume;
    mem_ctrl_t  mem;
    logic [5:0] aux_rdata;
    logic [5:0] up_rdata;

    gsn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .volume  (volume)
    );

    gsn_mem u_mem (
        .clk       (clk),
        .ctrl      (mem),
        .aux_rdata (aux_rdata),
        .up_rdata  (up_rdata)
    );

    gsn_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .volume        (volume),
        .aux_rdata     (aux_rdata),
        .up_rdata      (up_rdata),
        .busy          (busy),
        .mem           (mem),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

// ===== rtl/core/gsn_checker.sv =====
// Port-level checker for the nibblizer and its bind to the top level.
module gsn_checker
    import gsn_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input result_t result,
    input logic    result_strobe
);

    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result word without a preceding busy cycle");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> $past(start && !busy))
        else $error("busy raised without an accepted word");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result words in consecutive cycles");

    a_last_is_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> (result.out_byte == 8'hFF))
        else $error("final word of the sector is not a gap nibble");

endmodule

bind gcr_sector_nibblizer gsn_checker u_gsn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result        (result),
    .result_strobe (result_strobe)
);
